// ===== rtl/core/rws_pkg.sv =====
// Shared types and constants of the roulette wheel selector.
`default_nettype none

package rws_pkg;

    // Default sizes
    localparam int POP_MAX_DEF    = 64;
    localparam int FIT_WIDTH_DEF  = 16;
    localparam int RAND_WIDTH_DEF = 16;

    // Port field widths
    localparam int OP_FIELD_W   = 2;
    localparam int FIT_FIELD_W  = 16;
    localparam int RAND_FIELD_W = 16;
    localparam int IDX_FIELD_W  = 6;

    // Operation codes
    localparam logic [OP_FIELD_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_FIELD_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_FIELD_W-1:0] OP_DRAW  = 2'd2;

    // Status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [OP_FIELD_W-1:0]   op;
        logic [FIT_FIELD_W-1:0]  fitness_value;
        logic [RAND_FIELD_W-1:0] rand_frac;
    } t_in_item;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] selected_index;
        logic                   status;
    } t_out_item;

    // Control from the sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/roulette_wheel_selector.sv =====
// Top level of the roulette wheel selector: cell chain store, scan unit, sequencer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_in  (op, fitness, rand)
//  out     | out       | o_out_valid / i_out_stall | o_out (index, status)
//
// Clear and load do not stall the input. A draw on a nonempty store rotates the
// cell chain once around, one entry per cycle, and stalls the input side until its
// result is taken into the output register; a draw on an empty store or zero total skips the walk.
// Reset clears count, total and handshake state; cell contents are not reset.
// A result waits in the sequencer while the output register is stalled.
`default_nettype none

module roulette_wheel_selector #(
    parameter int POP_MAX    = rws_pkg::POP_MAX_DEF,
    parameter int FIT_WIDTH  = rws_pkg::FIT_WIDTH_DEF,
    parameter int RAND_WIDTH = rws_pkg::RAND_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rws_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rws_pkg::t_out_item      o_out
);

    localparam int CNT_W = $clog2(POP_MAX + 1);
    localparam int IDX_W = $clog2(POP_MAX);
    localparam int TOT_W = FIT_WIDTH + IDX_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [TOT_W-1:0]   r_total;
    logic [CNT_W-1:0]   r_j;
    logic               r_empty;
    logic               r_out_valid;
    rws_pkg::t_out_item r_out;

    logic [FIT_WIDTH-1:0]  w_fit;
    logic [RAND_WIDTH-1:0] w_rand;
    logic                  w_accept;
    logic                  w_load_ok;
    logic                  w_draw;
    logic                  w_draw_empty;
    logic                  w_shift;
    logic                  w_out_free;
    logic                  w_found;
    logic [IDX_W-1:0]      w_pick;
    logic [IDX_W-1:0]      w_res_idx;
    rws_pkg::t_scan_ctl    w_ctl;
    logic [FIT_WIDTH-1:0]  w_cell_fit [POP_MAX];

    assign w_fit        = FIT_WIDTH'(i_in.fitness_value);
    assign w_rand       = RAND_WIDTH'(i_in.rand_frac);
    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_load_ok    = w_accept && (i_in.op == rws_pkg::OP_LOAD)
                          && (r_count < CNT_W'(POP_MAX));
    assign w_draw       = w_accept && (i_in.op == rws_pkg::OP_DRAW);
    assign w_draw_empty = (r_count == '0) || (r_total == '0);
    assign w_shift      = (r_state == S_WALK) && (r_j < CNT_W'(POP_MAX));
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign w_ctl.start = w_draw && !w_draw_empty;
    assign w_ctl.step  = (r_state == S_WALK) && (r_j < r_count);

    // Store: a ring of cells, head at cell 0; one full turn restores load order
    for (genvar k = 0; k < POP_MAX; k++) begin : g_cell
        rws_cell #(
            .FIT_WIDTH (FIT_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_wr         (w_load_ok && (r_count == CNT_W'(k))),
            .i_wr_data    (w_fit),
            .i_shift      (w_shift),
            .i_shift_data (w_cell_fit[(k + 1) % POP_MAX]),
            .o_fit        (w_cell_fit[k])
        );
    end

    rws_scan #(
        .POP_MAX    (POP_MAX),
        .FIT_WIDTH  (FIT_WIDTH),
        .RAND_WIDTH (RAND_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rand  (w_rand),
        .i_total (r_total),
        .i_head  (w_cell_fit[0]),
        .i_idx   (r_j[IDX_W-1:0]),
        .o_found (w_found),
        .o_pick  (w_pick)
    );

    always_comb begin
        if (r_empty) begin
            w_res_idx = '0;
        end else if (w_found) begin
            w_res_idx = w_pick;
        end else begin
            w_res_idx = IDX_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_j         <= '0;
            r_empty     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.op)
                            rws_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                            end
                            rws_pkg::OP_LOAD: begin
                                if (w_load_ok) begin
                                    r_count <= r_count + 1'b1;
                                    r_total <= r_total + TOT_W'(w_fit);
                                end
                            end
                            rws_pkg::OP_DRAW: begin
                                r_empty <= w_draw_empty;
                                r_j     <= '0;
                                r_state <= w_draw_empty ? S_DONE : S_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    // the pass at r_j == POP_MAX, which does not shift, lets the last compare land
                    if (w_shift) begin
                        r_j <= r_j + 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.selected_index <= rws_pkg::IDX_FIELD_W'(w_res_idx);
            r_out.status         <= r_empty ? rws_pkg::STATUS_EMPTY : rws_pkg::STATUS_OK;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(POP_MAX))
        else $error("population count exceeds capacity");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_total == '0))
        else $error("nonzero total with empty store");

    a_found_on_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && !r_empty) |-> w_found)
        else $error("walk ended without a selection on nonzero total");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result transaction without a finished draw");

endmodule

`default_nettype wire

// ===== rtl/core/rws_cell.sv =====
// One store cell: holds one fitness entry, loads by address, rotates with its neighbor.
`default_nettype none

module rws_cell #(
    parameter int FIT_WIDTH = rws_pkg::FIT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr,
    input  wire logic [FIT_WIDTH-1:0] i_wr_data,
    input  wire logic                 i_shift,
    input  wire logic [FIT_WIDTH-1:0] i_shift_data,
    output logic      [FIT_WIDTH-1:0] o_fit
);

    logic [FIT_WIDTH-1:0] r_fit;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_fit <= i_wr_data;
        end else if (i_shift) begin
            r_fit <= i_shift_data;
        end
    end

    assign o_fit = r_fit;

endmodule

`default_nettype wire

// ===== rtl/core/rws_scan.sv =====
// Scan unit: running cumulative sum and exact wheel compare against r * total.
`default_nettype none

module rws_scan #(
    parameter int POP_MAX    = rws_pkg::POP_MAX_DEF,
    parameter int FIT_WIDTH  = rws_pkg::FIT_WIDTH_DEF,
    parameter int RAND_WIDTH = rws_pkg::RAND_WIDTH_DEF
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire rws_pkg::t_scan_ctl                     i_ctl,
    input  wire logic [RAND_WIDTH-1:0]                  i_rand,
    input  wire logic [FIT_WIDTH+$clog2(POP_MAX)-1:0]   i_total,
    input  wire logic [FIT_WIDTH-1:0]                   i_head,
    input  wire logic [$clog2(POP_MAX)-1:0]             i_idx,
    output logic                                        o_found,
    output logic      [$clog2(POP_MAX)-1:0]             o_pick
);

    localparam int IDX_W  = $clog2(POP_MAX);
    localparam int TOT_W  = FIT_WIDTH + IDX_W;
    localparam int PROD_W = RAND_WIDTH + TOT_W;

    logic [PROD_W-1:0] r_prod;
    logic [TOT_W-1:0]  r_cum;
    logic              r_chk;
    logic [IDX_W-1:0]  r_chk_idx;
    logic              r_found;
    logic [IDX_W-1:0]  r_pick;

    logic [PROD_W:0]   w_lhs;
    logic [PROD_W:0]   w_rhs;
    logic              w_hit;

    // r * total <= cum * (2^RW - 1)  <=>  r * total + cum <= cum << RW
    assign w_lhs = (PROD_W+1)'(r_prod) + (PROD_W+1)'(r_cum);
    assign w_rhs = (PROD_W+1)'({r_cum, {RAND_WIDTH{1'b0}}});
    assign w_hit = r_chk && !r_found && (w_lhs <= w_rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_chk   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_chk <= i_ctl.step;
            if (w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= i_idx;
        if (i_ctl.start) begin
            r_prod <= i_rand * i_total;
            r_cum  <= '0;
        end else if (i_ctl.step) begin
            r_cum <= r_cum + TOT_W'(i_head);
        end
        if (w_hit) begin
            r_pick <= r_chk_idx;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;

endmodule

`default_nettype wire
